// File: design/assert_macros.svh
// assertion macros used by the checker file
// expects signals named clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define SRW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked assertion that also holds through reset
`define SRW_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/srw_pkg.sv
// types, codes and constants of the supervisor register watchdog
// no dependencies
`timescale 1ns / 1ps

package srw_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_MSG   = 2'd3
  } func_t;

  // register ids carried by a received message
  localparam logic [3:0] CMD_WD_INTERVAL = 4'd0;
  localparam logic [3:0] CMD_SLEEP       = 4'd1;
  localparam logic [3:0] CMD_CLEAR_WD    = 4'd2;
  localparam logic [3:0] CMD_OFF         = 4'd3;
  localparam logic [3:0] CMD_EE_ADDR     = 4'd4;
  localparam logic [3:0] CMD_LOAD        = 4'd5;
  localparam logic [3:0] CMD_SAVE        = 4'd6;
  localparam logic [3:0] CMD_READ_AREA   = 4'd7;
  localparam logic [3:0] CMD_WRITE_AREA  = 4'd8;

  // eeprom request codes
  localparam logic [2:0] EOP_NONE      = 3'd0;
  localparam logic [2:0] EOP_STORE_WD  = 3'd1;
  localparam logic [2:0] EOP_STORE_SLP = 3'd2;
  localparam logic [2:0] EOP_LOAD      = 3'd3;
  localparam logic [2:0] EOP_SAVE      = 3'd4;

  typedef enum logic [4:0] {
    SEQ_IDLE  = 5'b00001,
    SEQ_WR    = 5'b00010,
    SEQ_RD    = 5'b00100,
    SEQ_OFF   = 5'b01000,
    SEQ_PULSE = 5'b10000
  } seq_state_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_WR   = 2'd1,
    ACT_RD   = 2'd2,
    ACT_OFF  = 2'd3
  } action_t;

  localparam int ACNT_W = 10;
  localparam logic [ACNT_W-1:0] BUSY_MS  = 10'd10;
  localparam logic [ACNT_W-1:0] OFF_MS   = 10'd1000;
  localparam logic [ACNT_W-1:0] PULSE_MS = 10'd10;
  localparam logic [3:0]        AREA_LEN = 4'd8;
  localparam int                SAVE_AREA_BASE = 24;

  // store access request from the input side
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [4:0] pos;
    logic [7:0] wdata;
  } store_req_t;

  function automatic logic [3:0] length_of(input logic [3:0] cmd, input logic m2s);
    logic [3:0] len;
    len = 4'd0;
    case (cmd)
      CMD_WD_INTERVAL, CMD_SLEEP: len = 4'd4;
      CMD_CLEAR_WD, CMD_OFF, CMD_LOAD, CMD_SAVE: len = m2s ? 4'd1 : 4'd0;
      CMD_EE_ADDR: len = 4'd2;
      CMD_READ_AREA: len = m2s ? 4'd0 : AREA_LEN;
      CMD_WRITE_AREA: len = m2s ? AREA_LEN : 4'd0;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

// File: design/srw_in_if.sv
// input channel: event transactions into the register watchdog
// depends on srw_pkg
`timescale 1ns / 1ps

interface srw_in_if import srw_pkg::*; ();
  logic       valid;
  logic       ready;
  func_t      func;
  logic [4:0] position;
  logic [7:0] data_byte;
  logic [3:0] command;
  logic       to_slave;

  modport source (output valid, func, position, data_byte, command, to_slave, input ready);
  modport sink (input valid, func, position, data_byte, command, to_slave, output ready);
endinterface

// File: design/srw_out_if.sv
// output channel: result transactions of the register watchdog
// no dependencies
`timescale 1ns / 1ps

interface srw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [3:0]  msg_len;
  logic        busy_res;
  logic [2:0]  eeprom_op;
  logic [15:0] eeprom_address;
  logic [31:0] eeprom_word;
  logic        watchdog_pulse;
  logic        sleep_request;

  modport source (output valid, read_data, msg_len, busy_res, eeprom_op, eeprom_address,
                  eeprom_word, watchdog_pulse, sleep_request, input ready);
  modport sink (input valid, read_data, msg_len, busy_res, eeprom_op, eeprom_address,
                eeprom_word, watchdog_pulse, sleep_request, output ready);
endinterface

// File: design/srw_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module srw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: design/srw_store.sv
// byte register store: four ram copies give four bytes from position on and
// the save-area word in one access; per-entry valid bits read zero until written
// depends on srw_pkg and srw_ram
`timescale 1ns / 1ps

module srw_store import srw_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  store_req_t       req,
  output logic [3:0][7:0]  pos_bytes,
  output logic [3:0][7:0]  save_bytes
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [9:0] DEPTH1 = 10'(DEPTH);
  localparam logic [9:0] DEPTH2 = 10'(2 * DEPTH);

  // index modulo depth, the sum never reaches three times the depth
  function automatic logic [AW-1:0] wrap_idx(input logic [9:0] v);
    logic [9:0] w;
    w = v;
    if (w >= DEPTH2) begin
      w = w - DEPTH2;
    end else if (w >= DEPTH1) begin
      w = w - DEPTH1;
    end
    return w[AW-1:0];
  endfunction

  logic [DEPTH-1:0]  valid;
  logic [AW-1:0]     waddr;
  logic [3:0][AW-1:0] raddr;
  logic [3:0][7:0]   pos_raw;
  logic [3:0][7:0]   save_raw;
  logic [3:0]        pos_vld;
  logic [3:0]        save_vld;

  assign waddr = wrap_idx(10'(req.pos));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr) begin
      valid[waddr] <= 1'b1;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_copy
    localparam int SI = (SAVE_AREA_BASE + k) % DEPTH;

    assign raddr[k] = wrap_idx(10'(req.pos) + 10'(k));

    srw_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (req.wr),
      .waddr   (waddr),
      .wdata   (req.wdata),
      .re_a    (req.rd),
      .raddr_a (raddr[k]),
      .rdata_a (pos_raw[k]),
      .re_b    (req.rd),
      .raddr_b (AW'(SI)),
      .rdata_b (save_raw[k])
    );

    always_ff @(posedge clk) begin
      if (req.rd) begin
        pos_vld[k]  <= valid[raddr[k]];
        save_vld[k] <= valid[SI];
      end
    end

    assign pos_bytes[k]  = pos_vld[k] ? pos_raw[k] : 8'd0;
    assign save_bytes[k] = save_vld[k] ? save_raw[k] : 8'd0;
  end

endmodule

// File: design/supervisor_register_watchdog.sv
// supervisor register block: byte store, message decode, watchdog and action sequencer
// depends on srw_pkg, srw_in_if, srw_out_if and srw_store
//
//   channel   dir   carries
//   item      in    func, position, data_byte, command, to_slave
//   result    out   read_data, msg_len, busy_res, eeprom_op, eeprom_address,
//                   eeprom_word, watchdog_pulse, sleep_request
//
// one transaction per cycle while results are taken; an item is read from the
// store at accept into the read stage, then moves on to the result register
// synchronous reset clears all control state and the per-entry valid bits of
// the store at once, no clearing pass; item.ready stays low while reset is high
// a stalled result holds the result stage, then the read stage, then item.ready
`timescale 1ns / 1ps

module supervisor_register_watchdog import srw_pkg::*; #(
  parameter int STORE_BYTES = 32
) (
  input logic       clk,
  input logic       rst,
  srw_in_if.sink    item,
  srw_out_if.source result
);

  // read stage: item fields beside the registered store data
  logic            s1_valid;
  func_t           s1_func;
  logic [3:0]      s1_cmd;
  logic            s1_to_slave;
  logic            s1_adv;
  logic            in_acc;
  store_req_t      store_req;
  logic [3:0][7:0] pos_bytes;
  logic [3:0][7:0] save_bytes;

  // block state
  seq_state_t          seq;
  seq_state_t          seq_next;
  action_t             pend;
  action_t             pend_next;
  logic [ACNT_W-1:0]   act_cnt;
  logic [ACNT_W-1:0]   act_cnt_next;
  logic [31:0]         wd_cnt;
  logic [31:0]         wd_cnt_next;
  logic [31:0]         wd_int;
  logic [31:0]         wd_int_next;
  logic [15:0]         ee_ptr;
  logic [15:0]         ee_ptr_next;
  logic                sleep_flag;
  logic                sleep_next;

  // per-item results
  logic        expired;
  logic [2:0]  op;
  logic [31:0] word;
  logic [7:0]  rd;
  logic [31:0] pos_word;
  logic [31:0] save_word;

  // result register frees when empty or taken; read stage follows it
  assign s1_adv     = !result.valid || result.ready;
  assign item.ready = !rst && (!s1_valid || s1_adv);
  assign in_acc     = item.valid && item.ready;

  // writes land at the accept edge, so any later item reads them
  assign store_req.wr    = in_acc && (item.func == FUNC_WRITE);
  assign store_req.rd    = in_acc;
  assign store_req.pos   = item.position;
  assign store_req.wdata = item.data_byte;

  srw_store #(
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (store_req),
    .pos_bytes  (pos_bytes),
    .save_bytes (save_bytes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func     <= item.func;
      s1_cmd      <= item.command;
      s1_to_slave <= item.to_slave;
    end
  end

  // big-endian words straight from the store bytes
  assign pos_word  = {pos_bytes[0], pos_bytes[1], pos_bytes[2], pos_bytes[3]};
  assign save_word = {save_bytes[0], save_bytes[1], save_bytes[2], save_bytes[3]};
  assign expired   = (wd_cnt == 32'd0);

  always_comb begin
    seq_next     = seq;
    pend_next    = pend;
    act_cnt_next = act_cnt;
    wd_cnt_next  = wd_cnt;
    wd_int_next  = wd_int;
    ee_ptr_next  = ee_ptr;
    sleep_next   = sleep_flag;
    op           = EOP_NONE;
    word         = 32'd0;
    rd           = 8'd0;
    case (s1_func)
      FUNC_TICK: begin
        // watchdog runs down in every sequencer state
        if (!expired) begin
          wd_cnt_next = wd_cnt - 32'd1;
        end
        case (seq)
          SEQ_IDLE: begin
            if (pend == ACT_WR) begin
              act_cnt_next = BUSY_MS;
              seq_next     = SEQ_WR;
            end else if (pend == ACT_RD) begin
              act_cnt_next = BUSY_MS;
              seq_next     = SEQ_RD;
            end else if (pend == ACT_OFF) begin
              act_cnt_next = OFF_MS;
              seq_next     = SEQ_OFF;
            end
            // expiry wins, the pending action waits for the pulse to end
            if (expired) begin
              act_cnt_next = PULSE_MS;
              seq_next     = SEQ_PULSE;
            end
          end
          SEQ_WR, SEQ_RD: begin
            if (act_cnt == '0) begin
              seq_next  = SEQ_IDLE;
              pend_next = ACT_NONE;
            end else begin
              act_cnt_next = act_cnt - 1'b1;
            end
          end
          SEQ_OFF: begin
            if (act_cnt == '0) begin
              seq_next   = SEQ_IDLE;
              pend_next  = ACT_NONE;
              sleep_next = 1'b1;
            end else begin
              act_cnt_next = act_cnt - 1'b1;
            end
          end
          SEQ_PULSE: begin
            // end of pulse rearms the watchdog
            if (act_cnt == '0) begin
              wd_cnt_next = wd_int;
              seq_next    = SEQ_IDLE;
            end else begin
              act_cnt_next = act_cnt - 1'b1;
            end
          end
          default: seq_next = SEQ_IDLE;
        endcase
      end
      FUNC_WRITE: begin
        // handled by the store at accept
      end
      FUNC_READ: rd = pos_bytes[0];
      FUNC_MSG: begin
        case (s1_cmd)
          CMD_WD_INTERVAL: begin
            word        = pos_word;
            wd_int_next = pos_word;
            pend_next   = ACT_WR;
            op          = EOP_STORE_WD;
          end
          CMD_SLEEP: begin
            word      = pos_word;
            pend_next = ACT_WR;
            op        = EOP_STORE_SLP;
          end
          CMD_CLEAR_WD: wd_cnt_next = wd_int;
          CMD_OFF:      sleep_next = 1'b1;
          // address halfword sits one byte after the message start
          CMD_EE_ADDR:  ee_ptr_next = {pos_bytes[1], pos_bytes[2]};
          CMD_LOAD: begin
            pend_next = ACT_RD;
            op        = EOP_LOAD;
          end
          CMD_SAVE: begin
            word      = save_word;
            pend_next = ACT_WR;
            op        = EOP_SAVE;
          end
          default: begin
            // other ids only decode a length
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // state and result move together when the read stage advances
  always_ff @(posedge clk) begin
    if (rst) begin
      seq          <= SEQ_IDLE;
      pend         <= ACT_NONE;
      act_cnt      <= '0;
      wd_cnt       <= 32'd0;
      wd_int       <= 32'd0;
      ee_ptr       <= 16'd0;
      sleep_flag   <= 1'b0;
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= s1_valid;
      if (s1_valid) begin
        seq        <= seq_next;
        pend       <= pend_next;
        act_cnt    <= act_cnt_next;
        wd_cnt     <= wd_cnt_next;
        wd_int     <= wd_int_next;
        ee_ptr     <= ee_ptr_next;
        sleep_flag <= sleep_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      result.read_data      <= rd;
      result.msg_len        <= length_of(s1_cmd, s1_to_slave);
      result.busy_res       <= (seq_next != SEQ_IDLE);
      result.eeprom_op      <= op;
      result.eeprom_address <= ee_ptr_next;
      result.eeprom_word    <= word;
      result.watchdog_pulse <= (seq_next == SEQ_PULSE);
      result.sleep_request  <= sleep_next;
    end
  end

endmodule

// File: design/srw_checker.sv
// port-level checks of the supervisor register watchdog, bound to the top level
// depends on srw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srw_checker import srw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  read_data,
  input logic        busy_res,
  input logic [2:0]  eeprom_op,
  input logic [15:0] eeprom_address,
  input logic [31:0] eeprom_word,
  input logic        watchdog_pulse,
  input logic        sleep_request
);

  // sleep request once delivered stays set until reset
  logic seen_sleep;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_sleep <= 1'b0;
    end else if (res_valid && res_ready && sleep_request) begin
      seen_sleep <= 1'b1;
    end
  end

  `SRW_ASSERT_RST(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(eeprom_word) && $stable(eeprom_address) && $stable(read_data) && $stable(eeprom_op), "stalled result changed")
  `SRW_ASSERT_RST(a_pulse_busy, res_valid && watchdog_pulse |-> busy_res, "pulse without busy")
  `SRW_ASSERT_CLK(a_op_range, res_valid && !rst |-> eeprom_op <= EOP_SAVE, "eeprom op out of range")
  `SRW_ASSERT_RST(a_word_idle, res_valid && eeprom_op == EOP_NONE |-> eeprom_word == 32'd0, "word without eeprom op")
  `SRW_ASSERT_RST(a_sleep_sticky, res_valid && seen_sleep |-> sleep_request, "sleep request dropped")

endmodule

bind supervisor_register_watchdog srw_checker u_srw_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .read_data      (result.read_data),
  .busy_res       (result.busy_res),
  .eeprom_op      (result.eeprom_op),
  .eeprom_address (result.eeprom_address),
  .eeprom_word    (result.eeprom_word),
  .watchdog_pulse (result.watchdog_pulse),
  .sleep_request  (result.sleep_request)
);

// File: tb/tb_top.sv
// self-checking testbench of supervisor_register_watchdog: directed and random bus events
// depends on srw_pkg, srw_in_if, srw_out_if and the block itself
`timescale 1ns / 1ps

module tb_top;
  import srw_pkg::*;

  localparam int STORE_N     = 32;
  localparam int RANDOM_GOAL = 1050;
  localparam int STALL_LIMIT = 3000;  // covers the long hold-off plus the longest gaps
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 500;   // accepted events before the long hold-off
  localparam int DRAIN_WAIT  = 20;

  // one bus event as offered on the input channel
  typedef struct {
    func_t      func;
    logic [4:0] position;
    logic [7:0] data_byte;
    logic [3:0] command;
    logic       to_slave;
  } bus_event_t;

  // status word returned for every event
  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  msg_len;
    logic        busy_res;
    logic [2:0]  eeprom_op;
    logic [15:0] eeprom_address;
    logic [31:0] eeprom_word;
    logic        watchdog_pulse;
    logic        sleep_request;
  } status_t;

  logic clk;
  logic rst;

  srw_in_if  evt ();
  srw_out_if res ();

  supervisor_register_watchdog #(.STORE_BYTES(STORE_N)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (evt),
    .result (res)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor state: register file, watchdog and action sequencer
  // ---------------------------------------------------------------------------
  logic [7:0]  byte_store [STORE_N];
  seq_state_t  seq;
  action_t     pend;
  logic [9:0]  act_cnt;
  logic [31:0] wd_cnt;
  logic [31:0] wd_interval;
  logic [15:0] ee_ptr;
  logic        sleep_bit;

  bus_event_t  event_queue [$];   // events still to be offered
  status_t     status_due [$];    // predicted status words, oldest first

  int errors = 0;
  int random_items = 0;
  bit in_random = 1'b0;
  int accepted_events = 0;
  int checked = 0;
  int n_ticks = 0, n_writes = 0, n_reads = 0, n_msgs = 0;
  int n_pulse = 0, n_busy = 0, n_eeops = 0;

  // big-endian word starting at p, wrapping around the store
  function automatic logic [31:0] word_from(input logic [4:0] p);
    return {byte_store[p], byte_store[p + 5'd1], byte_store[p + 5'd2], byte_store[p + 5'd3]};
  endfunction

  // message length per register id and direction
  function automatic logic [3:0] bytes_for(input logic [3:0] cmd, input logic m2s);
    case (cmd)
      CMD_WD_INTERVAL, CMD_SLEEP: return 4'd4;
      CMD_CLEAR_WD, CMD_OFF, CMD_LOAD, CMD_SAVE: return m2s ? 4'd1 : 4'd0;
      CMD_EE_ADDR: return 4'd2;
      CMD_READ_AREA: return m2s ? 4'd0 : AREA_LEN;
      CMD_WRITE_AREA: return m2s ? AREA_LEN : 4'd0;
      default: return 4'd0;
    endcase
  endfunction

  // one tick of an eeprom or switch-off wait: count down, or at the end back to idle, pending action dropped
  function automatic void wait_tick(input logic to_sleep);
    if (act_cnt == '0) begin
      seq = SEQ_IDLE;
      pend = ACT_NONE;
      if (to_sleep) sleep_bit = 1'b1;
    end else begin
      act_cnt = act_cnt - 10'd1;
    end
  endfunction

  // one millisecond tick of the watchdog and the sequencer
  function automatic void advance_ms();
    logic expired;
    expired = (wd_cnt == '0);
    if (!expired) wd_cnt = wd_cnt - 32'd1;
    case (seq)
      SEQ_IDLE: begin
        case (pend)
          ACT_WR: begin
            act_cnt = BUSY_MS;
            seq = SEQ_WR;
          end
          ACT_RD: begin
            act_cnt = BUSY_MS;
            seq = SEQ_RD;
          end
          ACT_OFF: begin
            act_cnt = OFF_MS;
            seq = SEQ_OFF;
          end
          default: ;
        endcase
        // an expired watchdog wins over the action, which stays pending
        if (expired) begin
          act_cnt = PULSE_MS;
          seq = SEQ_PULSE;
        end
      end
      SEQ_WR, SEQ_RD: wait_tick(1'b0);
      SEQ_OFF: wait_tick(1'b1);
      SEQ_PULSE: begin
        if (act_cnt == '0) begin
          wd_cnt = wd_interval;
          seq = SEQ_IDLE;
        end else begin
          act_cnt = act_cnt - 10'd1;
        end
      end
      default: ;
    endcase
  endfunction

  // apply one event to the predictor and return the status it produces
  function automatic status_t next_status(input bus_event_t ev);
    status_t st;
    st = '0;
    case (ev.func)
      FUNC_TICK: advance_ms();
      FUNC_WRITE: byte_store[ev.position] = ev.data_byte;
      FUNC_READ: st.read_data = byte_store[ev.position];
      default: begin
        case (ev.command)
          CMD_WD_INTERVAL: begin
            st.eeprom_word = word_from(ev.position);
            wd_interval = st.eeprom_word;
            pend = ACT_WR;
            st.eeprom_op = EOP_STORE_WD;
          end
          CMD_SLEEP: begin
            st.eeprom_word = word_from(ev.position);
            pend = ACT_WR;
            st.eeprom_op = EOP_STORE_SLP;
          end
          CMD_CLEAR_WD: wd_cnt = wd_interval;
          CMD_OFF: sleep_bit = 1'b1;
          CMD_EE_ADDR: ee_ptr = {byte_store[ev.position + 5'd1], byte_store[ev.position + 5'd2]};
          CMD_LOAD: begin
            pend = ACT_RD;
            st.eeprom_op = EOP_LOAD;
          end
          CMD_SAVE: begin
            st.eeprom_word = word_from(5'(SAVE_AREA_BASE));
            pend = ACT_WR;
            st.eeprom_op = EOP_SAVE;
          end
          default: ;  // unused ids only decode a length
        endcase
      end
    endcase
    st.msg_len = bytes_for(ev.command, ev.to_slave);
    st.busy_res = (seq != SEQ_IDLE);
    st.eeprom_address = ee_ptr;
    st.watchdog_pulse = (seq == SEQ_PULSE);
    st.sleep_request = sleep_bit;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_event(input func_t f, input logic [4:0] p, input logic [7:0] d,
                            input logic [3:0] c, input logic m2s);
    bus_event_t ev;
    ev.func = f;
    ev.position = p;
    ev.data_byte = d;
    ev.command = c;
    ev.to_slave = m2s;
    event_queue.push_back(ev);
    if (in_random) random_items++;
  endtask

  function automatic logic [4:0] any_pos();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] any_cmd();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // four byte writes, most significant byte first, wrapping the index
  task automatic put_word(input logic [4:0] p, input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      push_event(FUNC_WRITE, p + 5'(i), w[31 - 8 * i -: 8], any_cmd(), any_bit());
    end
  endtask

  // ticks with random don't-care fields, so the length decode sees every id
  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) push_event(FUNC_TICK, any_pos(), any_byte(), any_cmd(), any_bit());
  endtask

  // mostly short intervals so that pulses and eeprom waits interleave
  function automatic logic [31:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'($urandom_range(0, 40));
    if (r < 90) return 32'($urandom_range(41, 400));
    return $urandom();
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued events, new values at the falling edge
  // ---------------------------------------------------------------------------
  bit         in_fire = 1'b0;
  int         gap_left = 0;
  int         drv_cycle = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  bus_event_t drv_ev;

  always @(negedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else begin
      drv_cycle++;
      if (!evt.valid || in_fire) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
          evt.valid <= 1'b0;
        end else if (event_queue.size() > 0) begin
          drv_ev = event_queue.pop_front();
          evt.valid <= 1'b1;
          evt.func <= drv_ev.func;
          evt.position <= drv_ev.position;
          evt.data_byte <= drv_ev.data_byte;
          evt.command <= drv_ev.command;
          evt.to_slave <= drv_ev.to_slave;
          // back-to-back stretches, and no gaps while the receiver holds off
          if ((drv_cycle % 450) >= 350 || hold_left > 0) gap_left = 0;
          else gap_left = pick_gap();
        end else begin
          evt.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off to back up the pipeline
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int sink_cycle = 0;

  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      sink_cycle++;
      if (!hold_done && accepted_events >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if ((sink_cycle % 500) >= 100) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted event, checks every accepted status
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  bus_event_t seen;
  status_t    due;
  status_t    oldest;
  status_t    got;

  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire = evt.valid && evt.ready;
      if (in_fire) begin
        seen.func = evt.func;
        seen.position = evt.position;
        seen.data_byte = evt.data_byte;
        seen.command = evt.command;
        seen.to_slave = evt.to_slave;
        due = next_status(seen);
        status_due.push_back(due);
        accepted_events++;
        case (seen.func)
          FUNC_TICK: n_ticks++;
          FUNC_WRITE: n_writes++;
          FUNC_READ: n_reads++;
          default: n_msgs++;
        endcase
        if (due.watchdog_pulse) n_pulse++;
        if (due.busy_res) n_busy++;
        if (due.eeprom_op != EOP_NONE) n_eeops++;
      end
      if (res.valid && res.ready) begin
        got.read_data = res.read_data;
        got.msg_len = res.msg_len;
        got.busy_res = res.busy_res;
        got.eeprom_op = res.eeprom_op;
        got.eeprom_address = res.eeprom_address;
        got.eeprom_word = res.eeprom_word;
        got.watchdog_pulse = res.watchdog_pulse;
        got.sleep_request = res.sleep_request;
        if (status_due.size() == 0) begin
          $display("%0t: status transaction with nothing expected, actual %h", $time, got);
          errors++;
        end else begin
          oldest = status_due.pop_front();
          checked++;
          check_field("read_data", 32'(oldest.read_data), 32'(got.read_data));
          check_field("msg_len", 32'(oldest.msg_len), 32'(got.msg_len));
          check_field("busy_res", 32'(oldest.busy_res), 32'(got.busy_res));
          check_field("eeprom_op", 32'(oldest.eeprom_op), 32'(got.eeprom_op));
          check_field("eeprom_address", 32'(oldest.eeprom_address), 32'(got.eeprom_address));
          check_field("eeprom_word", oldest.eeprom_word, got.eeprom_word);
          check_field("watchdog_pulse", 32'(oldest.watchdog_pulse), 32'(got.watchdog_pulse));
          check_field("sleep_request", 32'(oldest.sleep_request), 32'(got.sleep_request));
        end
      end
    end
  end

  // watchdog on the testbench itself: too long without any transaction
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (evt.valid && evt.ready) || (res.valid && res.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d status words outstanding",
                 $time, quiet_cycles, status_due.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  int          pick;
  logic [4:0]  p;
  logic [3:0]  c;

  initial begin
    rst = 1'b1;

    // predictor reset
    foreach (byte_store[i]) byte_store[i] = '0;
    seq = SEQ_IDLE;
    pend = ACT_NONE;
    act_cnt = '0;
    wd_cnt = '0;
    wd_interval = '0;
    ee_ptr = '0;
    sleep_bit = 1'b0;

    // directed: empty store read, expired watchdog at reset, wrapped word and
    // halfword, every register id as a message, some in both directions, extremes of the fields
    push_event(FUNC_READ, 5'd0, 8'h00, CMD_WD_INTERVAL, 1'b0);
    push_event(FUNC_TICK, 5'd31, 8'hFF, 4'd15, 1'b1);
    push_event(FUNC_WRITE, 5'd30, 8'hA5, CMD_SLEEP, 1'b0);
    push_event(FUNC_WRITE, 5'd31, 8'hFF, CMD_SLEEP, 1'b1);
    push_event(FUNC_WRITE, 5'd0, 8'h5A, CMD_SLEEP, 1'b0);
    push_event(FUNC_WRITE, 5'd1, 8'h00, CMD_SLEEP, 1'b1);
    push_event(FUNC_READ, 5'd31, 8'h00, CMD_EE_ADDR, 1'b0);
    push_event(FUNC_MSG, 5'd30, 8'h00, CMD_WD_INTERVAL, 1'b1);
    push_event(FUNC_MSG, 5'd31, 8'hFF, CMD_SLEEP, 1'b0);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_CLEAR_WD, 1'b1);
    push_event(FUNC_MSG, 5'd5, 8'h00, CMD_CLEAR_WD, 1'b0);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_EE_ADDR, 1'b1);
    push_event(FUNC_MSG, 5'd30, 8'h00, CMD_EE_ADDR, 1'b0);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_LOAD, 1'b1);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_SAVE, 1'b0);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_READ_AREA, 1'b0);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_READ_AREA, 1'b1);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_WRITE_AREA, 1'b1);
    push_event(FUNC_MSG, 5'd0, 8'h00, CMD_WRITE_AREA, 1'b0);
    push_event(FUNC_MSG, 5'd31, 8'hFF, 4'd15, 1'b1);
    push_event(FUNC_MSG, 5'd0, 8'h00, 4'd9, 1'b0);
    push_event(FUNC_TICK, 5'd0, 8'h00, CMD_CLEAR_WD, 1'b0);
    push_event(FUNC_MSG, 5'd3, 8'h00, CMD_OFF, 1'b1);
    push_event(FUNC_READ, 5'd31, 8'hFF, CMD_OFF, 1'b0);

    // random: mostly well-formed register sequences, some followed by tick runs
    in_random = 1'b1;
    while (random_items < RANDOM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // program an interval and, mostly, restart the watchdog
        p = any_pos();
        put_word(p, pick_interval());
        push_event(FUNC_MSG, p, any_byte(), CMD_WD_INTERVAL, any_bit());
        if ($urandom_range(0, 3) != 0)
          push_event(FUNC_MSG, any_pos(), any_byte(), CMD_CLEAR_WD, any_bit());
        run_ticks($urandom_range(1, 30));
      end else if (pick < 40) begin
        // eeprom request, often issued again while the sequencer is busy
        case ($urandom_range(0, 2))
          0: c = CMD_SLEEP;
          1: c = CMD_LOAD;
          default: c = CMD_SAVE;
        endcase
        p = any_pos();
        if (c == CMD_SLEEP) put_word(p, $urandom());
        if (c == CMD_SAVE && $urandom_range(0, 1) == 1) put_word(5'(SAVE_AREA_BASE), $urandom());
        push_event(FUNC_MSG, p, any_byte(), c, any_bit());
        run_ticks($urandom_range(1, 25));
      end else if (pick < 50) begin
        // eeprom address from the halfword after the start byte
        p = any_pos();
        push_event(FUNC_WRITE, p + 5'd1, any_byte(), any_cmd(), any_bit());
        push_event(FUNC_WRITE, p + 5'd2, any_byte(), any_cmd(), any_bit());
        push_event(FUNC_MSG, p, any_byte(), CMD_EE_ADDR, any_bit());
      end else if (pick < 65) begin
        run_ticks($urandom_range(1, 60));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) push_event(FUNC_READ, any_pos(), any_byte(), any_cmd(), any_bit());
      end else if (pick < 80) begin
        // clear, switch-off and ids that only decode a length
        case ($urandom_range(0, 2))
          0: c = CMD_CLEAR_WD;
          1: c = CMD_OFF;
          default: c = 4'($urandom_range(7, 15));
        endcase
        push_event(FUNC_MSG, any_pos(), any_byte(), c, any_bit());
      end else begin
        // noise: every field fully random
        repeat ($urandom_range(1, 4))
          push_event(func_t'(2'($urandom_range(0, 3))), any_pos(), any_byte(), any_cmd(), any_bit());
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // drain: all events taken and every predicted status returned
    while (event_queue.size() != 0 || evt.valid || status_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d events: %0d ticks, %0d writes, %0d reads, %0d messages; %0d checked",
             accepted_events, n_ticks, n_writes, n_reads, n_msgs, checked);
    $display("sequencer busy on %0d results, pulse on %0d, eeprom requests %0d",
             n_busy, n_pulse, n_eeops);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/srw_pkg.sv
design/srw_in_if.sv
design/srw_out_if.sv
design/srw_ram.sv
design/srw_store.sv
design/supervisor_register_watchdog.sv
design/srw_checker.sv
tb/tb_top.sv
